// ----- hw/rtl/ffa_pkg.sv -----
// shared constants, cell codes and types for the forest fire automaton step
`timescale 1ns / 1ps

package ffa_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 64;
  localparam int TOTAL_CELLS = GRID_WIDTH * GRID_HEIGHT;

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);
  // items taken in one frame run up to cells plus one row plus one
  localparam int POS_W = $clog2(TOTAL_CELLS + GRID_WIDTH + 1);

  // field widths
  localparam int CELL_W     = 2;
  localparam int RND_W      = 16;
  localparam int DIV_W      = 16;
  localparam int COLUMN_W   = 7;
  localparam int ROWF_W     = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int LINE_W     = 2 * CELL_W;
  localparam int STEP_W     = $clog2(RND_W + 1);

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_GROW  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT = 1'b1;

  localparam int GROW_RESET_VAL = 250;
  localparam logic [DIV_W-1:0] GROW_RESET  = DIV_W'(GROW_RESET_VAL);
  localparam logic [DIV_W-1:0] LIGHT_RESET = DIV_W'(10 * GROW_RESET_VAL);

  // cell codes
  typedef logic [CELL_W-1:0] cell_t;
  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_TREE  = 2'd1;
  localparam cell_t CELL_FIRE  = 2'd2;
  localparam cell_t CELL_BAD   = 2'd3;

  // which window borders lie inside the grid
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // request to the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
    logic [RND_W-1:0] dividend;
  } mod_req_t;

endpackage

// ----- hw/rtl/ffa_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hw/rtl/ffa_mod_unit.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module ffa_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::mod_req_t req_i,
  output logic              busy_o,
  output logic              zero_o
);
  import ffa_pkg::*;

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem_r, dvd_r[RND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (req_i.start) begin
      rem_nxt = '0;
      dvd_nxt = req_i.dividend;
      div_nxt = req_i.divisor;
      cnt_nxt = STEP_W'(RND_W);
    end else if (cnt_r != '0) begin
      // partial remainder stays below the divisor, or holds a dividend prefix for zero
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign busy_o = (cnt_r != '0);
  assign zero_o = (rem_r == '0);

endmodule

// ----- hw/rtl/ffa_window.sv -----
// 3x3 neighbourhood window and next-state rule
`timescale 1ns / 1ps

module ffa_window (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_i,
  input  ffa_pkg::cell_t   upper_i,
  input  ffa_pkg::cell_t   middle_i,
  input  ffa_pkg::cell_t   cell_i,
  input  ffa_pkg::border_t border_i,
  input  logic             hit_i,
  output ffa_pkg::cell_t   centre_o,
  output ffa_pkg::cell_t   next_cell_o
);
  import ffa_pkg::*;

  cell_t win_r   [9];
  cell_t win_nxt [9];
  logic  burning;
  logic  [8:0] fire;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r*3+0] = win_r[r*3+1];
        win_nxt[r*3+1] = win_r[r*3+2];
      end
      win_nxt[2] = upper_i;
      win_nxt[5] = middle_i;
      win_nxt[8] = cell_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= CELL_EMPTY;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      fire[i] = (win_r[i] == CELL_FIRE);
    end
  end

  // neighbours outside the grid count as empty
  assign burning =
      (border_i.top    && border_i.left  && fire[0]) ||
      (border_i.top                      && fire[1]) ||
      (border_i.top    && border_i.right && fire[2]) ||
      (border_i.left                     && fire[3]) ||
      (border_i.right                    && fire[5]) ||
      (border_i.bottom && border_i.left  && fire[6]) ||
      (border_i.bottom                   && fire[7]) ||
      (border_i.bottom && border_i.right && fire[8]);

  assign centre_o = win_r[4];

  always_comb begin
    unique case (win_r[4])
      CELL_EMPTY: next_cell_o = hit_i ? CELL_TREE : CELL_EMPTY;
      CELL_TREE:  next_cell_o = (hit_i || burning) ? CELL_FIRE : CELL_TREE;
      CELL_FIRE:  next_cell_o = CELL_EMPTY;
      default:    next_cell_o = CELL_EMPTY;
    endcase
  end

endmodule

// ----- hw/rtl/forest_fire_automaton_step.sv -----
// top level: one forest fire generation over a raster-order cell stream
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | tdata cell_state, random_value; tuser flush
//  out_    | master    | out_tvalid / out_tready | tdata next_cell, column, row; tlast
//  cfg_    | write     | cfg_we                  | cfg_addr, cfg_wdata
//
//  an item that emits a cell goes through accept, line buffer read and window shift,
//  remainder start, 16 steps of the bit-serial remainder unit, a done cycle, output load
//  the first row plus one item of a frame emit nothing and end after the line buffer access
//  the remainder unit, one dividend bit per cycle, sets the rate
//  reset is synchronous and active low; the line buffers are not cleared, rows
//  outside the grid are masked so stale content is never used
//  a finished cell waits in the output register while the next item is worked on;
//  the sequencer only stalls at output load when that register is still full

module forest_fire_automaton_step (
  input  logic                              clk,
  input  logic                              rst_n,
  // cell_state [1:0], random_value [17:2], zero fill [23:18]
  input  logic [ffa_pkg::IN_DATA_W-1:0]     in_tdata,
  // flush [0]
  input  logic [0:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // next_cell [1:0], out_column [8:2], out_row [14:9], zero fill [15]
  output logic [ffa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // last_of_frame
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [ffa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ffa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ffa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DIV_W-1:0] grow_r, grow_nxt;
  logic [DIV_W-1:0] light_r, light_nxt;

  // captured item
  cell_t            cell_r, cell_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;

  // positions
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic             accept;
  logic             out_free;
  logic             frame_end;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic             line_we;
  cell_t            line_upper;
  cell_t            line_middle;
  cell_t            in_cell;
  logic             shift;
  border_t          border;
  mod_req_t         mod_req;
  logic             mod_busy;
  logic             mod_zero;
  cell_t            centre;
  cell_t            next_cell;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // a bad cell code, a flush or a cell below the grid all enter as empty
  assign in_cell = ((in_tdata[CELL_W-1:0] == CELL_BAD) || in_tuser[0] ||
                    (pos_r >= POS_W'(TOTAL_CELLS))) ? CELL_EMPTY : in_tdata[CELL_W-1:0];

  // line buffer pair: upper row in the high half, middle row in the low half
  assign line_upper  = line_rd[LINE_W-1:CELL_W];
  assign line_middle = line_rd[CELL_W-1:0];
  assign line_we     = (state_r == S_LOAD);
  assign line_wr     = {line_middle, cell_r};
  assign shift       = (state_r == S_LOAD);

  ffa_ram #(
    .WIDTH(LINE_W),
    .DEPTH(GRID_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(in_col_r),
    .wdata(line_wr),
    .raddr(in_col_r),
    .rdata(line_rd)
  );

  assign border.top    = (out_row_r != '0);
  assign border.bottom = (out_row_r != ROW_W'(GRID_HEIGHT - 1));
  assign border.left   = (out_col_r != '0);
  assign border.right  = (out_col_r != COL_W'(GRID_WIDTH - 1));

  ffa_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_i    (shift),
    .upper_i    (line_upper),
    .middle_i   (line_middle),
    .cell_i     (cell_r),
    .border_i   (border),
    .hit_i      (mod_zero),
    .centre_o   (centre),
    .next_cell_o(next_cell)
  );

  // tree cells test against the lightning divisor, all others against grow
  assign mod_req.start    = (state_r == S_START);
  assign mod_req.divisor  = (centre == CELL_TREE) ? light_r : grow_r;
  assign mod_req.dividend = rnd_r;

  ffa_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mod_req),
    .busy_o(mod_busy),
    .zero_o(mod_zero)
  );

  assign frame_end = (out_col_r == COL_W'(GRID_WIDTH - 1)) &&
                     (out_row_r == ROW_W'(GRID_HEIGHT - 1));

  // configuration writes
  always_comb begin
    grow_nxt  = grow_r;
    light_nxt = light_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GROW:  grow_nxt  = cfg_wdata;
        CFG_LIGHT: light_nxt = cfg_wdata;
        default:   grow_nxt  = grow_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cell_nxt      = cell_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    in_col_nxt    = in_col_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cell_nxt  = in_cell;
          rnd_nxt   = in_tdata[CELL_W +: RND_W];
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        pos_nxt    = pos_r + POS_W'(1);
        in_col_nxt = (in_col_r == COL_W'(GRID_WIDTH - 1)) ? '0 : in_col_r + COL_W'(1);
        // the first row plus one item only fill the window
        state_nxt  = (pos_r >= POS_W'(GRID_WIDTH + 1)) ? S_START : S_IDLE;
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!mod_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ROWF_W'(out_row_r), COLUMN_W'(out_col_r), next_cell};
          out_last_nxt  = frame_end;
          if (frame_end) begin
            pos_nxt     = '0;
            in_col_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (out_col_r == COL_W'(GRID_WIDTH - 1)) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grow_r      <= GROW_RESET;
      light_r     <= LIGHT_RESET;
      pos_r       <= '0;
      in_col_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grow_r      <= grow_nxt;
      light_r     <= light_nxt;
      pos_r       <= pos_nxt;
      in_col_r    <= in_col_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cell_r     <= cell_nxt;
    rnd_r      <= rnd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // an accepted item always goes on to the line buffer access
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOAD))
    else $error("accepted item did not reach line buffer stage");

  // the remainder unit only runs while the sequencer waits on it
  a_mod_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mod_busy |-> (state_r == S_DIV))
    else $error("remainder unit busy outside its wait state");

  // item count never passes the end of the drain
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(TOTAL_CELLS + GRID_WIDTH + 1))
    else $error("item count beyond frame drain");

  // a result loaded at frame end restarts all position counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free && frame_end) |=>
      (pos_r == '0 && out_col_r == '0 && out_row_r == '0 && out_tlast))
    else $error("frame end did not restart positions");

endmodule

// ----- test/ffa_generation_check.sv -----
// next-generation cell predictor and output comparison for the forest fire step
`timescale 1ns / 1ps

module ffa_generation_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ffa_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                     in_tuser,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [ffa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [ffa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ffa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             error_count,
  output int                             pending,
  output int                             items_seen,
  output int                             cells_checked,
  output int                             frames_done
);
  import ffa_pkg::*;

  typedef struct packed {
    cell_t                 coming;
    logic [COLUMN_W-1:0]   column;
    logic [ROWF_W-1:0]     row;
    logic                  frame_end;
  } next_cell_t;

  next_cell_t       awaited_cells [$];
  cell_t            upper_row [GRID_WIDTH];
  cell_t            middle_row [GRID_WIDTH];
  cell_t            window [9];
  int unsigned      in_pos;
  int unsigned      out_pos;
  logic [DIV_W-1:0] grow_div;
  logic [DIV_W-1:0] fire_div;

  // a zero divisor leaves the draw as remainder
  function automatic bit hits_zero(logic [RND_W-1:0] value, logic [DIV_W-1:0] divisor);
    if (divisor == '0) return value == '0;
    return (value % divisor) == '0;
  endfunction

  // shift one item into the window, queue the cell it releases
  task automatic step_grid(cell_t code, logic [RND_W-1:0] rnd, logic flush);
    int unsigned q;
    int unsigned col_in;
    int unsigned ro;
    int unsigned co;
    cell_t       shifted;
    cell_t       centre;
    cell_t       coming;
    bit          burning;
    bit          top_ok;
    bit          bottom_ok;
    bit          left_ok;
    bit          right_ok;
    next_cell_t  due;
    q = in_pos;
    col_in = q % GRID_WIDTH;
    shifted = (code == CELL_BAD || flush || q >= TOTAL_CELLS) ? CELL_EMPTY : code;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = upper_row[col_in];
    window[5] = middle_row[col_in];
    window[8] = shifted;
    upper_row[col_in]  = middle_row[col_in];
    middle_row[col_in] = shifted;
    in_pos = q + 1;
    if (q < GRID_WIDTH + 1) return;

    ro = out_pos / GRID_WIDTH;
    co = out_pos % GRID_WIDTH;
    top_ok    = ro > 0;
    bottom_ok = ro + 1 < GRID_HEIGHT;
    left_ok   = co > 0;
    right_ok  = co + 1 < GRID_WIDTH;
    burning = 1'b0;
    for (int dr = 0; dr < 3; dr++) begin
      if ((dr == 0 && !top_ok) || (dr == 2 && !bottom_ok)) continue;
      for (int dc = 0; dc < 3; dc++) begin
        if ((dc == 0 && !left_ok) || (dc == 2 && !right_ok)) continue;
        if (dr == 1 && dc == 1) continue;
        if (window[dr*3+dc] == CELL_FIRE) burning = 1'b1;
      end
    end
    centre = window[4];
    if (centre == CELL_EMPTY)
      coming = hits_zero(rnd, grow_div) ? CELL_TREE : CELL_EMPTY;
    else if (centre == CELL_TREE)
      coming = (hits_zero(rnd, fire_div) || burning) ? CELL_FIRE : CELL_TREE;
    else
      coming = CELL_EMPTY;

    due.coming     = coming;
    due.column     = COLUMN_W'(co);
    due.row        = ROWF_W'(ro);
    due.frame_end  = (out_pos + 1 >= TOTAL_CELLS);
    awaited_cells.push_back(due);
    if (due.frame_end) begin
      in_pos  = 0;
      out_pos = 0;
    end else begin
      out_pos = out_pos + 1;
    end
  endtask

  task automatic check_field(string field, int want, int got, next_cell_t due);
    if (want != got) begin
      $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
               $time, field, due.row, due.column, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    next_cell_t due;
    if (!rst_n) begin
      awaited_cells.delete();
      for (int i = 0; i < GRID_WIDTH; i++) begin
        upper_row[i]  = CELL_EMPTY;
        middle_row[i] = CELL_EMPTY;
      end
      for (int i = 0; i < 9; i++) window[i] = CELL_EMPTY;
      in_pos        = 0;
      out_pos       = 0;
      grow_div      = GROW_RESET;
      fire_div      = LIGHT_RESET;
      error_count   = 0;
      items_seen    = 0;
      cells_checked = 0;
      frames_done   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GROW:  grow_div = cfg_wdata;
          CFG_LIGHT: fire_div = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (awaited_cells.size() == 0) begin
          $display("%0t: unexpected output item: next_cell %0d row %0d col %0d last %0d",
                   $time, out_tdata[1:0], out_tdata[9 +: ROWF_W],
                   out_tdata[2 +: COLUMN_W], out_tlast);
          error_count++;
        end else begin
          due = awaited_cells.pop_front();
          check_field("next_cell", due.coming, out_tdata[1:0], due);
          check_field("out_column", due.column, out_tdata[2 +: COLUMN_W], due);
          check_field("out_row", due.row, out_tdata[9 +: ROWF_W], due);
          check_field("last_of_frame", due.frame_end, out_tlast, due);
          cells_checked++;
          if (due.frame_end) frames_done++;
        end
      end
      if (in_tvalid && in_tready) begin
        step_grid(cell_t'(in_tdata[CELL_W-1:0]), in_tdata[CELL_W +: RND_W], in_tuser[0]);
        items_seen++;
      end
    end
    pending = awaited_cells.size();
  end

endmodule

// ----- test/forest_fire_automaton_step_tb.sv -----
// testbench top: cell stream stimulus, divisor phases and the final verdict
`timescale 1ns / 1ps

module forest_fire_automaton_step_tb;
  import ffa_pkg::*;

  // items in one frame: every cell, then one row plus one of drain
  localparam int FRAME_ITEMS     = TOTAL_CELLS + GRID_WIDTH + 1;
  localparam int DIRECTED_ITEMS  = 24;
  localparam int PHASES          = 8;
  // eight short phases, all inside the first frame
  localparam int ITEMS_PER_PHASE = 160;
  // cycles left after the last result so a silent item can finish
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int SQUEEZE_PHASE   = 4;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int error_count;
  int pending;
  int items_seen;
  int cells_checked;
  int frames_done;

  // stimulus side bookkeeping
  int               send_idle_pct = 31;
  int               recv_idle_pct = 31;
  int               phase_no;
  bit               held_off;
  int               frame_pos;
  logic [DIV_W-1:0] grow_setting;
  logic [DIV_W-1:0] fire_setting;

  forest_fire_automaton_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ffa_generation_check u_generation_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending       (pending),
    .items_seen    (items_seen),
    .cells_checked (cells_checked),
    .frames_done   (frames_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // draws that are multiples of a divisor make growth and lightning common
  function automatic logic [RND_W-1:0] multiple_of(logic [DIV_W-1:0] d);
    if (d == '0) return '0;
    return RND_W'(int'(d) * $urandom_range(0, 65535 / int'(d)));
  endfunction

  // present one item, with random gaps first, and hold it until taken
  task automatic offer(cell_t code, logic [RND_W-1:0] rnd, logic flush);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W - CELL_W - RND_W){1'b0}}, rnd, code};
    in_tuser  <= flush;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    frame_pos = (frame_pos + 1 == FRAME_ITEMS) ? 0 : frame_pos + 1;
  endtask

  // random frame: any cell code including bad, rare flush items in the grid, mostly flush items in the drain
  task automatic offer_random();
    int               pick;
    cell_t            code;
    logic [RND_W-1:0] rnd;
    logic             flush;
    pick = $urandom_range(0, 99);
    if (pick < 35)      code = CELL_EMPTY;
    else if (pick < 70) code = CELL_TREE;
    else if (pick < 93) code = CELL_FIRE;
    else                code = CELL_BAD;
    pick = $urandom_range(0, 99);
    if (pick < 20)      rnd = multiple_of(grow_setting);
    else if (pick < 35) rnd = multiple_of(fire_setting);
    else if (pick < 38) rnd = '0;
    else if (pick < 41) rnd = '1;
    else                rnd = RND_W'($urandom);
    if (frame_pos >= TOTAL_CELLS)
      flush = ($urandom_range(0, 99) < 75);
    else
      flush = ($urandom_range(0, 99) < 3);
    offer(code, rnd, flush);
  endtask

  // stop offering, wait for every outstanding cell, then let silent items finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both divisors in back-to-back cycles, enable dropped once after the pair
  task automatic write_divisors(logic [DIV_W-1:0] g, logic [DIV_W-1:0] f);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_GROW;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_addr  <= CFG_LIGHT;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grow_setting = g;
    fire_setting = f;
  endtask

  // result side: random stalls, plus one long hold-off while the input keeps coming
  initial begin : result_side
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_no == SQUEEZE_PHASE && !held_off) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    logic [DIV_W-1:0] g;
    logic [DIV_W-1:0] f;
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_GROW;
    cfg_wdata <= '0;
    phase_no     = 0;
    frame_pos    = 0;
    grow_setting = GROW_RESET;
    fire_setting = LIGHT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed start under reset divisors: all four cell codes, draw extremes,
    // flush items carrying a cell that must be dropped
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      case (i % 3)
        0:       g = '0;
        1:       g = '1;
        default: g = RND_W'(i * GROW_RESET_VAL);
      endcase
      offer(cell_t'(i % 4), g, (i % 7) == 6);
    end

    // divisor phases: always and never, zero, tiny, reset values, random
    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1:       begin g = 16'd1;     f = 16'hFFFF;    end
        2:       begin g = 16'hFFFF;  f = 16'd1;       end
        3:       begin g = 16'd0;     f = 16'd0;       end
        4:       begin g = 16'd2;     f = 16'd3;       end
        6:       begin g = GROW_RESET; f = LIGHT_RESET; end
        default: begin
          g = DIV_W'($urandom_range(1, 16));
          f = DIV_W'($urandom_range(1, 64));
        end
      endcase
      wait_idle();
      write_divisors(g, f);
      // the squeeze phase runs without random gaps on either side
      send_idle_pct = (ph == SQUEEZE_PHASE) ? 0 : 31;
      recv_idle_pct = (ph == SQUEEZE_PHASE) ? 0 : 31;
      phase_no = ph;
      repeat (ITEMS_PER_PHASE) offer_random();
    end
    wait_idle();

    $display("run: %0d items over %0d divisor settings, %0d frame ends seen",
             items_seen, PHASES + 1, frames_done);
    $display("run: %0d cells compared, with a %0d-cycle output hold-off under full input",
             cells_checked, HOLD_CYCLES);
    if (error_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_mod_unit.sv
hw/rtl/ffa_window.sv
hw/rtl/forest_fire_automaton_step.sv
test/ffa_generation_check.sv
test/forest_fire_automaton_step_tb.sv
